[rtl/core/imq_pkg.sv]
// Shared types and constants for the indexed min priority queue core.
// No dependencies; used by imq_ctrl, imq_dp and the top level.
`default_nettype none

package imq_pkg;

  localparam int HEAP_DEPTH_DEF = 1024;
  localparam int NODE_COUNT_DEF = 1024;
  localparam int COST_BITS_DEF  = 32;

  localparam int NODE_W  = 10;
  localparam int COST_W  = 32;
  localparam int COUNT_W = 11;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_PEEK   = 2'd2,
    OP_UPDATE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_ABSENT = 2'd3
  } status_t;

  typedef struct packed {
    op_t                operation;
    logic [NODE_W-1:0]  node_id;
    logic [COST_W-1:0]  new_cost;
  } in_req_t;

  typedef struct packed {
    logic [NODE_W-1:0]  out_node;
    logic [COST_W-1:0]  out_cost;
    logic [COUNT_W-1:0] entry_count;
    status_t            status;
  } out_rsp_t;

  // Datapath micro-operations issued by the controller.
  typedef enum logic [3:0] {
    DP_NOP,
    DP_CLR,
    DP_LOAD,
    DP_START_PUSH,
    DP_START_REKEY,
    DP_MOVE_UP,
    DP_SAVE_LEFT,
    DP_MOVE_DOWN,
    DP_PLACE,
    DP_POP_TAKE,
    DP_PEEK_TAKE,
    DP_HOLE_LAST,
    DP_FINISH
  } dp_op_t;

  // Heap memory read address select.
  typedef enum logic [2:0] {
    RD_TOP,
    RD_LAST,
    RD_POS,
    RD_PARENT,
    RD_LEFT,
    RD_RIGHT
  } rd_sel_t;

  typedef struct packed {
    dp_op_t  op;
    rd_sel_t rd;
    status_t status;
  } dp_cmd_t;

  typedef struct packed {
    op_t  req_op;
    logic node_oor;
    logic held;
    logic empty;
    logic full;
    logic at_root;
    logic up_less;
    logic has_left;
    logic dn_greater;
    logic grew;
    logic one_left;
    logic out_free;
    logic clr_last;
  } dp_stat_t;

endpackage

`default_nettype wire

[rtl/core/imq_ctrl.sv]
// Controller state machine of the indexed min priority queue core.
// Depends on imq_pkg; drives imq_dp through dp_cmd_t and reads dp_stat_t.
`default_nettype none

module imq_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  imq_pkg::dp_stat_t     stat,
  output imq_pkg::dp_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_DISPATCH,
    S_DECIDE,
    S_RK_START,
    S_UP,
    S_UP_CMP,
    S_DN,
    S_DN_R,
    S_DN_CMP,
    S_TAKE,
    S_LAST,
    S_FINISH
  } state_t;

  state_t             state_r, state_nxt;
  imq_pkg::status_t   status_r, status_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    cmd.op     = imq_pkg::DP_NOP;
    cmd.rd     = imq_pkg::RD_TOP;
    cmd.status = status_r;
    unique case (state_r)
      S_CLR: begin
        cmd.op = imq_pkg::DP_CLR;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = imq_pkg::DP_LOAD;
          status_nxt = imq_pkg::ST_OK;
          state_nxt  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.req_op == imq_pkg::OP_POP || stat.req_op == imq_pkg::OP_PEEK) begin
          if (stat.empty) begin
            status_nxt = imq_pkg::ST_EMPTY;
            state_nxt  = S_FINISH;
          end else begin
            cmd.rd    = imq_pkg::RD_TOP;
            state_nxt = S_TAKE;
          end
        end else begin
          // position lookup lands next cycle
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.node_oor) begin
          status_nxt = imq_pkg::ST_ABSENT;
          state_nxt  = S_FINISH;
        end else if (stat.held) begin
          cmd.rd    = imq_pkg::RD_POS;
          state_nxt = S_RK_START;
        end else if (stat.req_op == imq_pkg::OP_UPDATE) begin
          status_nxt = imq_pkg::ST_ABSENT;
          state_nxt  = S_FINISH;
        end else if (stat.full) begin
          status_nxt = imq_pkg::ST_FULL;
          state_nxt  = S_FINISH;
        end else begin
          cmd.op    = imq_pkg::DP_START_PUSH;
          state_nxt = S_UP;
        end
      end
      S_RK_START: begin
        cmd.op    = imq_pkg::DP_START_REKEY;
        state_nxt = stat.grew ? S_DN : S_UP;
      end
      S_UP: begin
        if (stat.at_root) begin
          cmd.op    = imq_pkg::DP_PLACE;
          state_nxt = S_FINISH;
        end else begin
          cmd.rd    = imq_pkg::RD_PARENT;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat.up_less) begin
          cmd.op    = imq_pkg::DP_MOVE_UP;
          state_nxt = S_UP;
        end else begin
          cmd.op    = imq_pkg::DP_PLACE;
          state_nxt = S_FINISH;
        end
      end
      S_DN: begin
        if (!stat.has_left) begin
          cmd.op    = imq_pkg::DP_PLACE;
          state_nxt = S_FINISH;
        end else begin
          cmd.rd    = imq_pkg::RD_LEFT;
          state_nxt = S_DN_R;
        end
      end
      S_DN_R: begin
        cmd.op    = imq_pkg::DP_SAVE_LEFT;
        cmd.rd    = imq_pkg::RD_RIGHT;
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (stat.dn_greater) begin
          cmd.op    = imq_pkg::DP_MOVE_DOWN;
          state_nxt = S_DN;
        end else begin
          cmd.op    = imq_pkg::DP_PLACE;
          state_nxt = S_FINISH;
        end
      end
      S_TAKE: begin
        if (stat.req_op == imq_pkg::OP_POP) begin
          cmd.op = imq_pkg::DP_POP_TAKE;
          if (stat.one_left) begin
            state_nxt = S_FINISH;
          end else begin
            cmd.rd    = imq_pkg::RD_LAST;
            state_nxt = S_LAST;
          end
        end else begin
          cmd.op    = imq_pkg::DP_PEEK_TAKE;
          state_nxt = S_FINISH;
        end
      end
      S_LAST: begin
        cmd.op    = imq_pkg::DP_HOLE_LAST;
        state_nxt = S_DN;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.op    = imq_pkg::DP_FINISH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      status_r <= imq_pkg::ST_OK;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_DISPATCH))
    else $error("accepted request did not start dispatch");

  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == imq_pkg::DP_FINISH) |=> !in_stall)
    else $error("controller not idle after finishing a request");

  a_clr_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> in_stall)
    else $error("request accepted during clearing pass");

endmodule

`default_nettype wire

[rtl/core/imq_dp.sv]
// Datapath of the indexed min priority queue core: heap and position memories,
// sift registers and result register. Depends on imq_pkg; driven by imq_ctrl.
`default_nettype none

module imq_dp #(
  parameter int HEAP_DEPTH = imq_pkg::HEAP_DEPTH_DEF,
  parameter int NODE_COUNT = imq_pkg::NODE_COUNT_DEF,
  parameter int COST_BITS  = imq_pkg::COST_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  imq_pkg::in_req_t      in_data,
  input  imq_pkg::dp_cmd_t      cmd,
  output imq_pkg::dp_stat_t     stat,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output imq_pkg::out_rsp_t     out_data
);

  localparam int SLOT_W = $clog2(HEAP_DEPTH);
  localparam int SIZE_W = $clog2(HEAP_DEPTH + 1);
  localparam int NIDX_W = $clog2(NODE_COUNT);
  localparam int CMP_W  = SLOT_W + 2;
  localparam int NODE_W = imq_pkg::NODE_W;
  localparam int ENT_W  = NODE_W + COST_BITS;

  logic [ENT_W-1:0]    heap_mem_r [HEAP_DEPTH];
  logic [SLOT_W:0]     ns_mem_r   [NODE_COUNT];

  logic [ENT_W-1:0]    hrd_data_r;
  logic [SLOT_W-1:0]   hrd_addr;
  logic [SLOT_W:0]     ns_rd_data_r;
  logic [NIDX_W-1:0]   ns_rd_addr;

  logic                heap_we;
  logic [SLOT_W-1:0]   heap_wa;
  logic [ENT_W-1:0]    heap_wd;
  logic                ns_we;
  logic [NIDX_W-1:0]   ns_wa;
  logic [SLOT_W:0]     ns_wd;

  imq_pkg::op_t        req_op_r;
  logic [NODE_W-1:0]   req_node_r;
  logic [COST_BITS-1:0] req_cost_r;
  logic [SIZE_W-1:0]   size_r;
  logic [NIDX_W-1:0]   clr_idx_r;
  logic [SLOT_W-1:0]   pos_r;
  logic [NODE_W-1:0]   hole_node_r;
  logic [COST_BITS-1:0] hole_cost_r;
  logic [NODE_W-1:0]   pick_node_r;
  logic [COST_BITS-1:0] pick_cost_r;
  logic [SLOT_W-1:0]   pick_pos_r;
  logic [NODE_W-1:0]   res_node_r;
  logic [COST_BITS-1:0] res_cost_r;
  logic                out_valid_r;
  imq_pkg::out_rsp_t   out_data_r;

  logic [NODE_W-1:0]   rd_node;
  logic [COST_BITS-1:0] rd_cost;
  logic [SLOT_W-1:0]   pos_m1;
  logic [SLOT_W-1:0]   parent;
  logic [CMP_W-1:0]    left_w;
  logic [CMP_W-1:0]    right_w;
  logic [CMP_W-1:0]    size_w;
  logic                has_left;
  logic                has_right;
  logic                use_right;
  logic [NODE_W-1:0]   eff_node;
  logic [COST_BITS-1:0] eff_cost;
  logic [SLOT_W-1:0]   eff_pos;
  logic [SIZE_W-1:0]   size_m1;

  assign rd_node   = hrd_data_r[COST_BITS +: NODE_W];
  assign rd_cost   = hrd_data_r[COST_BITS-1:0];
  assign pos_m1    = pos_r - SLOT_W'(1);
  assign parent    = pos_m1 >> 1;
  assign left_w    = {1'b0, pos_r, 1'b1};
  assign right_w   = left_w + CMP_W'(1);
  assign size_w    = CMP_W'(size_r);
  assign has_left  = left_w < size_w;
  assign has_right = right_w < size_w;
  assign size_m1   = size_r - SIZE_W'(1);

  // take the right child only when strictly smaller
  assign use_right = has_right && (rd_cost < pick_cost_r);
  assign eff_node  = use_right ? rd_node : pick_node_r;
  assign eff_cost  = use_right ? rd_cost : pick_cost_r;
  assign eff_pos   = use_right ? SLOT_W'(right_w) : pick_pos_r;

  assign ns_rd_addr = NIDX_W'(req_node_r);

  always_comb begin
    case (cmd.rd)
      imq_pkg::RD_TOP:    hrd_addr = '0;
      imq_pkg::RD_LAST:   hrd_addr = SLOT_W'(size_m1);
      imq_pkg::RD_POS:    hrd_addr = ns_rd_data_r[SLOT_W-1:0];
      imq_pkg::RD_PARENT: hrd_addr = parent;
      imq_pkg::RD_LEFT:   hrd_addr = SLOT_W'(left_w);
      imq_pkg::RD_RIGHT:  hrd_addr = SLOT_W'(right_w);
      default:            hrd_addr = '0;
    endcase
  end

  always_comb begin
    heap_we = 1'b0;
    heap_wa = pos_r;
    heap_wd = {hole_node_r, hole_cost_r};
    ns_we   = 1'b0;
    ns_wa   = NIDX_W'(hole_node_r);
    ns_wd   = {1'b1, pos_r};
    case (cmd.op)
      imq_pkg::DP_CLR: begin
        ns_we = 1'b1;
        ns_wa = clr_idx_r;
        ns_wd = '0;
      end
      imq_pkg::DP_MOVE_UP: begin
        heap_we = 1'b1;
        heap_wd = hrd_data_r;
        ns_we   = 1'b1;
        ns_wa   = NIDX_W'(rd_node);
      end
      imq_pkg::DP_MOVE_DOWN: begin
        heap_we = 1'b1;
        heap_wd = {eff_node, eff_cost};
        ns_we   = 1'b1;
        ns_wa   = NIDX_W'(eff_node);
      end
      imq_pkg::DP_PLACE: begin
        heap_we = 1'b1;
        ns_we   = 1'b1;
      end
      imq_pkg::DP_POP_TAKE: begin
        ns_we = 1'b1;
        ns_wa = NIDX_W'(rd_node);
        ns_wd = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    hrd_data_r   <= heap_mem_r[hrd_addr];
    ns_rd_data_r <= ns_mem_r[ns_rd_addr];
    if (heap_we) heap_mem_r[heap_wa] <= heap_wd;
    if (ns_we)   ns_mem_r[ns_wa]     <= ns_wd;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= '0;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == imq_pkg::DP_FINISH) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        imq_pkg::DP_CLR:        clr_idx_r <= clr_idx_r + NIDX_W'(1);
        imq_pkg::DP_START_PUSH: size_r    <= size_r + SIZE_W'(1);
        imq_pkg::DP_POP_TAKE:   size_r    <= size_m1;
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (cmd.op) inside
      imq_pkg::DP_LOAD: begin
        req_op_r   <= in_data.operation;
        req_node_r <= in_data.node_id;
        req_cost_r <= COST_BITS'(in_data.new_cost);
        res_node_r <= '0;
        res_cost_r <= '0;
      end
      imq_pkg::DP_START_PUSH: begin
        hole_node_r <= req_node_r;
        hole_cost_r <= req_cost_r;
        pos_r       <= SLOT_W'(size_r);
      end
      imq_pkg::DP_START_REKEY: begin
        hole_node_r <= req_node_r;
        hole_cost_r <= req_cost_r;
        pos_r       <= ns_rd_data_r[SLOT_W-1:0];
      end
      imq_pkg::DP_MOVE_UP:   pos_r <= parent;
      imq_pkg::DP_MOVE_DOWN: pos_r <= eff_pos;
      imq_pkg::DP_SAVE_LEFT: begin
        pick_node_r <= rd_node;
        pick_cost_r <= rd_cost;
        pick_pos_r  <= SLOT_W'(left_w);
      end
      imq_pkg::DP_POP_TAKE, imq_pkg::DP_PEEK_TAKE: begin
        res_node_r <= rd_node;
        res_cost_r <= rd_cost;
      end
      imq_pkg::DP_HOLE_LAST: begin
        hole_node_r <= rd_node;
        hole_cost_r <= rd_cost;
        pos_r       <= '0;
      end
      imq_pkg::DP_FINISH: begin
        out_data_r.out_node    <= res_node_r;
        out_data_r.out_cost    <= imq_pkg::COST_W'(res_cost_r);
        out_data_r.entry_count <= imq_pkg::COUNT_W'(size_r);
        out_data_r.status      <= cmd.status;
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    stat.req_op     = req_op_r;
    stat.node_oor   = (32'(req_node_r) >= NODE_COUNT);
    stat.held       = ns_rd_data_r[SLOT_W];
    stat.empty      = (size_r == '0);
    stat.full       = (size_r == SIZE_W'(HEAP_DEPTH));
    stat.at_root    = (pos_r == '0);
    stat.up_less    = (hole_cost_r < rd_cost);
    stat.has_left   = has_left;
    stat.dn_greater = (hole_cost_r > eff_cost);
    stat.grew       = (req_cost_r > rd_cost);
    stat.one_left   = (size_r == SIZE_W'(1));
    stat.out_free   = !out_valid_r || !out_stall;
    stat.clr_last   = (clr_idx_r == NIDX_W'(NODE_COUNT - 1));
  end

  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    size_r <= SIZE_W'(HEAP_DEPTH))
    else $error("heap size above depth");

  a_up_not_root: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == imq_pkg::DP_MOVE_UP) |-> (pos_r != '0))
    else $error("sift-up moved past the root");

  a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == imq_pkg::DP_FINISH) |=> out_valid_r)
    else $error("finished request left no result");

endmodule

`default_nettype wire

[rtl/core/indexed_min_priority_queue_core.sv]
// Top level of the indexed min priority queue core.
// Depends on imq_pkg, imq_ctrl and imq_dp.
//
//  channel  | ports                          | payload
//  ---------+--------------------------------+---------------------
//  request  | in_valid, in_stall, in_data    | imq_pkg::in_req_t
//  result   | out_valid, out_stall, out_data | imq_pkg::out_rsp_t
//
// From its accepting edge a request holds the core until its result is registered:
// a push or a lowered re-key sifts up, a pop or a raised re-key sifts down, and the
// registered heap memory read at each level paces the sift.
// After reset a clearing pass over every node index empties the position table;
// in_stall stays high during it.
// A finished result waits in the output register; the next request is
// accepted while it waits, and its result holds until the previous one is taken.
`default_nettype none

module indexed_min_priority_queue_core #(
  parameter int HEAP_DEPTH = imq_pkg::HEAP_DEPTH_DEF,
  parameter int NODE_COUNT = imq_pkg::NODE_COUNT_DEF,
  parameter int COST_BITS  = imq_pkg::COST_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  imq_pkg::in_req_t   in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output imq_pkg::out_rsp_t  out_data
);

  imq_pkg::dp_cmd_t  cmd;
  imq_pkg::dp_stat_t stat;

  imq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  imq_dp #(
    .HEAP_DEPTH (HEAP_DEPTH),
    .NODE_COUNT (NODE_COUNT),
    .COST_BITS  (COST_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[test/tb_indexed_min_priority_queue_core.sv]
// Testbench for indexed_min_priority_queue_core: drives push/pop/peek/update requests
// and checks every result against an indexed min-heap predictor held in the bench.
// Depends on imq_pkg and the core RTL.
`default_nettype none

module tb_indexed_min_priority_queue_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH   = imq_pkg::HEAP_DEPTH_DEF;
  localparam int NODES   = imq_pkg::NODE_COUNT_DEF;
  localparam int NODE_W  = imq_pkg::NODE_W;
  localparam int COST_W  = imq_pkg::COST_W;
  localparam int COUNT_W = imq_pkg::COUNT_W;
  localparam longint CYCLE_LIMIT = 300000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  imq_pkg::in_req_t in_data;
  logic out_valid;
  logic out_stall;
  imq_pkg::out_rsp_t out_data;

  indexed_min_priority_queue_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // predictor state
  logic [NODE_W-1:0] heap_node [DEPTH];
  logic [COST_W-1:0] heap_cost [DEPTH];
  int unsigned node_pos [NODES];
  bit node_held [NODES];
  int unsigned heap_count;

  imq_pkg::in_req_t request_q [$];
  imq_pkg::out_rsp_t result_q [$];
  int fail_count;
  longint cycle_count;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_off;
  bit hold_req;
  bit in_taken;

  task automatic report(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    fail_count++;
  endtask

  function automatic void swap_entries(int unsigned a, int unsigned b);
    logic [NODE_W-1:0] n;
    logic [COST_W-1:0] c;
    n = heap_node[a]; c = heap_cost[a];
    heap_node[a] = heap_node[b]; heap_cost[a] = heap_cost[b];
    heap_node[b] = n; heap_cost[b] = c;
    node_pos[heap_node[a]] = a;
    node_pos[heap_node[b]] = b;
  endfunction

  function automatic void bubble_up(int unsigned pos);
    int unsigned parent;
    while (pos > 0 && pos < heap_count) begin
      parent = (pos - 1) / 2;
      if (heap_cost[pos] < heap_cost[parent]) begin
        swap_entries(pos, parent);
        pos = parent;
      end else break;
    end
  endfunction

  function automatic void bubble_down(int unsigned pos);
    int unsigned lc, rc, pick;
    while (pos < heap_count) begin
      lc = 2 * pos + 1;
      rc = 2 * pos + 2;
      if (lc >= heap_count) break;
      pick = lc;
      if (rc < heap_count && heap_cost[rc] < heap_cost[lc]) pick = rc;
      if (heap_cost[pos] > heap_cost[pick]) begin
        swap_entries(pos, pick);
        pos = pick;
      end else break;
    end
  endfunction

  function automatic imq_pkg::out_rsp_t heap_apply(input imq_pkg::in_req_t req);
    imq_pkg::out_rsp_t r;
    int unsigned pos, last;
    logic [COST_W-1:0] old;
    r = '0;
    r.status = imq_pkg::ST_OK;
    if (req.operation == imq_pkg::OP_PUSH || req.operation == imq_pkg::OP_UPDATE) begin
      if (node_held[req.node_id]) begin
        pos = node_pos[req.node_id];
        old = heap_cost[pos];
        heap_cost[pos] = req.new_cost;
        if (req.new_cost > old) bubble_down(pos);
        else bubble_up(pos);
      end else if (req.operation == imq_pkg::OP_UPDATE) begin
        r.status = imq_pkg::ST_ABSENT;
      end else if (heap_count >= DEPTH) begin
        r.status = imq_pkg::ST_FULL;
      end else begin
        pos = heap_count;
        heap_node[pos] = req.node_id;
        heap_cost[pos] = req.new_cost;
        node_pos[req.node_id] = pos;
        node_held[req.node_id] = 1'b1;
        heap_count++;
        bubble_up(pos);
      end
    end else if (heap_count == 0) begin
      r.status = imq_pkg::ST_EMPTY;
    end else begin
      r.out_node = heap_node[0];
      r.out_cost = heap_cost[0];
      if (req.operation == imq_pkg::OP_POP) begin
        last = heap_count - 1;
        node_held[heap_node[0]] = 1'b0;
        if (last > 0) begin
          heap_node[0] = heap_node[last];
          heap_cost[0] = heap_cost[last];
          node_pos[heap_node[0]] = 0;
        end
        heap_count = last;
        bubble_down(0);
      end
    end
    r.entry_count = COUNT_W'(heap_count);
    return r;
  endfunction

  function automatic imq_pkg::in_req_t make_req(imq_pkg::op_t op, int unsigned node,
                                                logic [COST_W-1:0] cost);
    imq_pkg::in_req_t q;
    q.operation = op;
    q.node_id = NODE_W'(node);
    q.new_cost = cost;
    return q;
  endfunction

  task automatic add_req(input imq_pkg::in_req_t req);
    request_q.insert(request_q.size(), req);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
  end

  // driver: change inputs at the falling edge, advance only past an accepted request
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_taken) void'(request_q.pop_front());
      if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= request_q[0];
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // receiver hold-off, counted here once the stimulus asks for it
  initial begin
    int n;
    hold_off = 1'b0;
    wait (hold_req);
    hold_off = 1'b1;
    for (n = 0; n < 400; n++) @(posedge clk);
    hold_off = 1'b0;
  end

  // predict on accepted requests, check accepted results
  always @(posedge clk) begin
    imq_pkg::out_rsp_t exp_r;
    imq_pkg::out_rsp_t new_r;
    cycle_count <= cycle_count + 1;
    if (rst_n && in_valid && !in_stall) begin
      new_r = heap_apply(in_data);
      result_q.insert(result_q.size(), new_r);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        report("result with none expected");
      end else begin
        exp_r = result_q.pop_front();
        if (out_data.out_node !== exp_r.out_node)
          report($sformatf("out_node %0d exp %0d", out_data.out_node, exp_r.out_node));
        if (out_data.out_cost !== exp_r.out_cost)
          report($sformatf("out_cost %h exp %h", out_data.out_cost, exp_r.out_cost));
        if (out_data.entry_count !== exp_r.entry_count)
          report($sformatf("entry_count %0d exp %0d", out_data.entry_count,
                           exp_r.entry_count));
        if (out_data.status !== exp_r.status)
          report($sformatf("status %0d exp %0d", out_data.status, exp_r.status));
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic drain();
    while (request_q.size() != 0 || in_valid || result_q.size() != 0) @(posedge clk);
  endtask

  // well-formed mix with random content over a node pool of the given size
  task automatic add_random(int count, int pool);
    int k;
    for (k = 0; k < count; k++) begin
      case ($urandom_range(9)) inside
        [0:3]: add_req(make_req(imq_pkg::OP_PUSH, $urandom_range(pool - 1),
                                $urandom_range(3) == 0 ? $urandom()
                                                       : $urandom_range(40)));
        [4:5]: add_req(make_req(imq_pkg::OP_POP, $urandom_range(1023), $urandom()));
        6: add_req(make_req(imq_pkg::OP_PEEK, $urandom_range(1023), $urandom()));
        default: add_req(make_req(imq_pkg::OP_UPDATE, $urandom_range(pool - 1),
                                  $urandom_range(1) ? $urandom()
                                                    : $urandom_range(40)));
      endcase
    end
  endtask

  initial begin
    int k;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    hold_req = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fail_count = 0;
    cycle_count = 0;
    heap_count = 0;
    for (k = 0; k < NODES; k++) node_held[k] = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty cases, extremes, re-key both ways, absent node, equal costs
    add_req(make_req(imq_pkg::OP_POP, 0, 0));
    add_req(make_req(imq_pkg::OP_PEEK, 1023, '1));
    add_req(make_req(imq_pkg::OP_UPDATE, 5, 7));
    add_req(make_req(imq_pkg::OP_PUSH, 1023, 32'hFFFF_FFFF));
    add_req(make_req(imq_pkg::OP_PUSH, 0, 32'h0000_0000));
    add_req(make_req(imq_pkg::OP_PUSH, 7, 32'h0001_0000));
    add_req(make_req(imq_pkg::OP_PUSH, 8, 32'h0001_0000));
    add_req(make_req(imq_pkg::OP_PUSH, 9, 32'h0001_0000));
    add_req(make_req(imq_pkg::OP_PEEK, 0, 0));
    add_req(make_req(imq_pkg::OP_UPDATE, 0, 32'h0002_0000));
    add_req(make_req(imq_pkg::OP_UPDATE, 1023, 32'h0000_0001));
    add_req(make_req(imq_pkg::OP_PUSH, 9, 32'h0000_0000));
    add_req(make_req(imq_pkg::OP_UPDATE, 9, 32'h0000_0000));
    add_req(make_req(imq_pkg::OP_UPDATE, 512, 32'hAAAA_5555));
    add_req(make_req(imq_pkg::OP_PUSH, 341, 32'h5555_AAAA));
    for (k = 0; k < 8; k++) add_req(make_req(imq_pkg::OP_POP, 682, 0));
    drain();

    // long receiver hold-off while the sender keeps offering
    hold_req = 1'b1;
    add_random(60, 64);
    drain();

    add_random(190, 64);
    drain();
    send_idle_pct = 80;
    add_random(190, 32);
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 80;
    add_random(190, 128);
    drain();
    send_idle_pct = 25;
    recv_stall_pct = 25;
    add_random(190, 1024);
    drain();

    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
